FILE: src/tlt_pkg.sv
`timescale 1ns / 1ps

package tlt_pkg;

    // Table geometry
    localparam int LOCK_ENTRIES = 64;
    localparam int IDX_W        = $clog2(LOCK_ENTRIES);

    // Field widths
    localparam int DEV_W     = 8;
    localparam int PATH_W    = 64;
    localparam int TIME_W    = 32;
    localparam int DUR_W     = 16;
    localparam int REL_W     = 6;
    localparam int STAT_W    = 2;
    localparam int OUT_IDX_W = 6;

    // Stream packing
    localparam int IN_DATA_W  = 112;   // 110 payload bits, padded to bytes
    localparam int OUT_DATA_W = 8;

    // Release range check width: holds both the index and the entry count
    localparam int CMP_W = ((IDX_W > REL_W) ? IDX_W : REL_W) + 1;

    // Lock duration after reset, in seconds
    localparam logic [DUR_W-1:0] DUR_RESET = 16'd300;

    // Command codes
    localparam logic CMD_ACQUIRE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_HELD = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    typedef logic [IDX_W-1:0] t_idx;

    // Key and time of the request under search, broadcast to every entry
    typedef struct packed {
        logic [DEV_W-1:0]  dev;
        logic [PATH_W-1:0] path;
        logic [TIME_W-1:0] now;
    } t_req;

    // Search result handed from entry to entry
    typedef struct packed {
        logic vld;
        logic hit;
        logic free_ok;
        t_idx free_idx;
        logic exp_ok;
        t_idx exp_idx;
    } t_scan;

    // Table update broadcast
    typedef struct packed {
        logic              wr;
        logic              clr;
        logic              reclaim;
        t_idx              idx;
        logic [DEV_W-1:0]  dev;
        logic [PATH_W-1:0] path;
        logic [TIME_W-1:0] exp;
        logic [TIME_W-1:0] now;
    } t_upd;

endpackage

FILE: src/tlt_cell.sv
`timescale 1ns / 1ps

module tlt_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tlt_pkg::t_idx  i_idx,
    input  tlt_pkg::t_req  i_req,
    input  tlt_pkg::t_upd  i_upd,
    input  tlt_pkg::t_scan i_scan,
    output tlt_pkg::t_scan o_scan
);
    import tlt_pkg::*;

    logic [DEV_W-1:0]  r_dev;
    logic [PATH_W-1:0] r_path;
    logic [TIME_W-1:0] r_exp;
    t_scan             r_scan;
    t_scan             n_scan;
    logic              live;
    logic              is_free;
    logic              expired;
    logic              sel;

    // Local tests against the broadcast request
    always_comb begin
        is_free = (r_exp == '0);
        expired = (r_exp < i_req.now);
        live    = !is_free && !expired && (r_path == i_req.path) && (r_dev == i_req.dev);
    end

    // Fold this entry into the passing search result:
    // free keeps the highest index, expired keeps the lowest
    always_comb begin
        n_scan     = i_scan;
        n_scan.hit = i_scan.hit | live;
        if (is_free) begin
            n_scan.free_ok  = 1'b1;
            n_scan.free_idx = i_idx;
        end
        if (!i_scan.exp_ok && expired) begin
            n_scan.exp_ok  = 1'b1;
            n_scan.exp_idx = i_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan.vld <= 1'b0;
        end else begin
            r_scan <= n_scan;
        end
    end

    assign sel = (i_upd.idx == i_idx);

    // Expiry: zero means free; grant beats reclaim on the chosen entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp <= '0;
        end else if (i_upd.wr && sel) begin
            r_exp <= i_upd.exp;
        end else if (i_upd.clr && sel) begin
            r_exp <= '0;
        end else if (i_upd.reclaim && (r_exp < i_upd.now)) begin
            r_exp <= '0;
        end
    end

    // Key payload
    always_ff @(posedge i_clk) begin
        if (i_upd.wr && sel) begin
            r_dev  <= i_upd.dev;
            r_path <= i_upd.path;
        end
    end

    assign o_scan = r_scan;

endmodule

FILE: src/tlt_ctrl.sv
`timescale 1ns / 1ps

module tlt_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [tlt_pkg::IN_DATA_W-1:0]     i_s_tdata,
    input  logic                              i_s_tuser,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tlt_pkg::DUR_W-1:0]         i_cfg_data,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [tlt_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    output logic [tlt_pkg::STAT_W-1:0]        o_m_tuser,
    output tlt_pkg::t_scan                    o_seed,
    input  tlt_pkg::t_scan                    i_last,
    output tlt_pkg::t_req                     o_req,
    output tlt_pkg::t_upd                     o_upd
);
    import tlt_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]          r_state;
    logic [1:0]          n_state;
    logic [DUR_W-1:0]    r_dur;
    t_req                r_req;
    logic [TIME_W-1:0]   r_exp_new;
    logic                r_start;
    logic [STAT_W-1:0]   r_res_stat;
    logic [STAT_W-1:0]   n_res_stat;
    t_idx                r_res_idx;
    t_idx                n_res_idx;
    logic                r_m_valid;
    logic [STAT_W-1:0]   r_m_stat;
    logic [OUT_IDX_W-1:0] r_m_idx;

    logic                accept;
    logic                in_cmd;
    logic [DEV_W-1:0]    in_dev;
    logic [PATH_W-1:0]   in_path;
    logic [TIME_W-1:0]   in_now;
    logic [REL_W-1:0]    in_rel;
    logic                rel_ok;
    logic [TIME_W:0]     exp_sum;
    logic [TIME_W-1:0]   exp_val;
    logic                out_free;

    // Unpack request, lowest field first
    assign in_cmd  = i_s_tuser;
    assign in_dev  = i_s_tdata[DEV_W-1:0];
    assign in_path = i_s_tdata[DEV_W+PATH_W-1:DEV_W];
    assign in_now  = i_s_tdata[DEV_W+PATH_W+TIME_W-1:DEV_W+PATH_W];
    assign in_rel  = i_s_tdata[DEV_W+PATH_W+TIME_W+REL_W-1:DEV_W+PATH_W+TIME_W];

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_m_valid || i_m_tready;
    assign rel_ok     = (CMP_W'(in_rel) < CMP_W'(LOCK_ENTRIES));

    // Saturating expiry; zero is reserved for free entries
    always_comb begin
        exp_sum = {1'b0, in_now} + (TIME_W + 1)'(r_dur);
        if (exp_sum[TIME_W]) begin
            exp_val = '1;
        end else if (exp_sum[TIME_W-1:0] == '0) begin
            exp_val = TIME_W'(1);
        end else begin
            exp_val = exp_sum[TIME_W-1:0];
        end
    end

    // Configuration register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dur <= DUR_RESET;
        end else if (i_cfg_valid) begin
            r_dur <= i_cfg_data;
        end
    end

    // Search seed enters the first entry in the cycle after acceptance
    always_comb begin
        o_seed     = '0;
        o_seed.vld = r_start;
    end
    assign o_req = r_req;

    // Decision and table update
    always_comb begin
        n_state    = r_state;
        n_res_stat = r_res_stat;
        n_res_idx  = r_res_idx;
        o_upd      = '0;
        o_upd.dev  = r_req.dev;
        o_upd.path = r_req.path;
        o_upd.exp  = r_exp_new;
        o_upd.now  = r_req.now;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (in_cmd == CMD_RELEASE) begin
                        o_upd.clr  = rel_ok;
                        o_upd.idx  = IDX_W'(in_rel);
                        n_res_stat = ST_OK;
                        n_res_idx  = '0;
                        n_state    = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (i_last.vld) begin
                    n_state   = S_DONE;
                    n_res_idx = '0;
                    if (i_last.hit) begin
                        n_res_stat = ST_HELD;
                    end else if (i_last.free_ok) begin
                        o_upd.wr   = 1'b1;
                        o_upd.idx  = i_last.free_idx;
                        n_res_stat = ST_OK;
                        n_res_idx  = i_last.free_idx;
                    end else if (i_last.exp_ok) begin
                        o_upd.wr      = 1'b1;
                        o_upd.reclaim = 1'b1;
                        o_upd.idx     = i_last.exp_idx;
                        n_res_stat    = ST_OK;
                        n_res_idx     = i_last.exp_idx;
                    end else begin
                        n_res_stat = ST_FULL;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_start   <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= accept && (in_cmd == CMD_ACQUIRE);
            if ((r_state == S_DONE) && out_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Request, result and output payload
    always_ff @(posedge i_clk) begin
        r_res_stat <= n_res_stat;
        r_res_idx  <= n_res_idx;
        if (accept) begin
            r_req.dev  <= in_dev;
            r_req.path <= in_path;
            r_req.now  <= in_now;
            r_exp_new  <= exp_val;
        end
        if ((r_state == S_DONE) && out_free) begin
            r_m_stat <= r_res_stat;
            r_m_idx  <= OUT_IDX_W'(r_res_idx);
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = OUT_DATA_W'(r_m_idx);
    assign o_m_tuser  = r_m_stat;

endmodule

FILE: src/timed_lock_table.sv
`timescale 1ns / 1ps

// Timed exclusive lock table, keyed by device and file path.
// Slave stream: tuser is the command (acquire or release); tdata carries
// device, path, current time and release index. Master stream: tuser is
// the status (granted/released, held by a live lock, table full), tdata
// the granted entry index. Config channel: lock duration in seconds,
// taken in any cycle, to be written only while no request is in flight.
// An acquire walks a chain of LOCK_ENTRIES entry stages, one stage per
// cycle: the seed is registered, each stage registers the result, the
// decision is registered and then loaded into the output register. A
// release skips the chain; its registered decision goes to the output
// register. One request is worked on at a time; tready is high only
// between requests, so a new one waits until the last result is output.
// The result sits in an output register; a stalled receiver holds it
// there and the next request is not finished until it is taken.
// Reset clears every entry to free and sets the duration to 300 seconds;
// the block accepts requests as soon as reset is released.
module timed_lock_table (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave request stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // tdata: device_id[7:0], file_path[71:8], now_seconds[103:72],
    //        release_index[109:104], zero pad[111:110]
    input  logic [tlt_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // tuser: command[0]
    input  logic                              i_s_tuser,
    // configuration write
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tlt_pkg::DUR_W-1:0]         i_cfg_data,
    // master result stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // tdata: entry_index[5:0], zero pad[7:6]
    output logic [tlt_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    // tuser: status[1:0]
    output logic [tlt_pkg::STAT_W-1:0]        o_m_tuser
);
    import tlt_pkg::*;

    t_scan w_scan [LOCK_ENTRIES+1];
    t_req  w_req;
    t_upd  w_upd;

    tlt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_seed      (w_scan[0]),
        .i_last      (w_scan[LOCK_ENTRIES]),
        .o_req       (w_req),
        .o_upd       (w_upd)
    );

    // Entry chain, index 0 first
    for (genvar g = 0; g < LOCK_ENTRIES; g++) begin : g_entry
        tlt_cell u_entry (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(g)),
            .i_req   (w_req),
            .i_upd   (w_upd),
            .i_scan  (w_scan[g]),
            .o_scan  (w_scan[g+1])
        );
    end

endmodule

FILE: src/tlt_checker.sv
`timescale 1ns / 1ps

module tlt_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_tvalid,
    input logic                              o_s_tready,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [tlt_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    input logic [tlt_pkg::STAT_W-1:0]        o_m_tuser
);
    import tlt_pkg::*;

    // Result held while the receiver stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tuser)
        && $stable(o_m_tdata)))
        else $error("result changed while stalled");

    // No result right after reset
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // Status is one of the three defined codes
    a_stat_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser == ST_OK || o_m_tuser == ST_HELD ||
        o_m_tuser == ST_FULL))
        else $error("undefined status");

    // Refusals carry index zero
    a_refuse_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != ST_OK) |-> (o_m_tdata == '0))
        else $error("nonzero index on refusal");

    // One request at a time: busy right after acceptance
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request taken while busy");

endmodule

bind timed_lock_table tlt_checker u_tlt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

FILE: bench/timed_lock_table_tb.sv
`timescale 1ns / 1ps

module timed_lock_table_tb;
    import tlt_pkg::*;

    localparam int  KEY_POOL    = 96;
    localparam int  PHASES      = 10;
    localparam int  RAND_ITEMS  = 140;
    localparam int  LONG_HOLD   = 400;
    localparam int  TAIL_CYCLES = 100;
    localparam longint CYCLE_LIMIT = 1_500_000;

    // One lock request as seen on the slave stream
    typedef struct packed {
        logic              cmd;
        logic [DEV_W-1:0]  dev;
        logic [PATH_W-1:0] path;
        logic [TIME_W-1:0] now;
        logic [REL_W-1:0]  rel;
    } t_lock_req;

    // One reply as seen on the master stream
    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [OUT_IDX_W-1:0] idx;
    } t_lock_reply;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata   = '0;
    logic                  i_s_tuser   = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [DUR_W-1:0]      i_cfg_data  = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic [STAT_W-1:0]     o_m_tuser;

    timed_lock_table uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Shadow copy of the lock table and the duration register
    logic [DEV_W-1:0]  tab_dev  [LOCK_ENTRIES];
    logic [PATH_W-1:0] tab_path [LOCK_ENTRIES];
    logic [TIME_W-1:0] tab_exp  [LOCK_ENTRIES];
    logic [DUR_W-1:0]  lock_dur = DUR_RESET;

    t_lock_req   pending_requests[$];
    t_lock_reply awaited_replies[$];
    t_lock_req   cur_req    = '0;

    // Key pool for well-formed traffic
    logic [DEV_W-1:0]  key_dev  [KEY_POOL];
    logic [PATH_W-1:0] key_path [KEY_POOL];

    logic [TIME_W-1:0] clock_s   = '0;
    bit                calm      = 1'b0;
    bit                offering  = 1'b0;
    bit                req_taken = 1'b0;
    bit                long_hold_req = 1'b0;
    int                gap_left   = 0;
    int                stall_left = 0;
    int                errors     = 0;
    longint            cycles     = 0;

    initial begin
        for (int i = 0; i < LOCK_ENTRIES; i++) begin
            tab_dev[i]  = '0;
            tab_path[i] = '0;
            tab_exp[i]  = '0;
        end
    end

    // Apply one request to the shadow table and return its reply
    function automatic t_lock_reply compute_lock_reply(t_lock_req r);
        t_lock_reply       rep;
        logic [TIME_W:0]   sum;
        logic [TIME_W-1:0] new_exp;
        int                pick;
        bit                found;
        rep   = '{status: ST_OK, idx: '0};
        pick  = 0;
        found = 1'b0;
        if (r.cmd == CMD_RELEASE) begin
            if (r.rel < LOCK_ENTRIES)
                tab_exp[r.rel] = '0;
            return rep;
        end
        // a live lock on the same key refuses the request
        for (int i = 0; i < LOCK_ENTRIES; i++) begin
            if (tab_exp[i] != 0 && tab_exp[i] >= r.now &&
                tab_path[i] == r.path && tab_dev[i] == r.dev) begin
                rep.status = ST_HELD;
                return rep;
            end
        end
        // highest free entry
        for (int i = LOCK_ENTRIES - 1; i >= 0 && !found; i--) begin
            if (tab_exp[i] == 0) begin
                pick  = i;
                found = 1'b1;
            end
        end
        // table full: reclaim all expired, keep the lowest
        if (!found) begin
            for (int i = LOCK_ENTRIES - 1; i >= 0; i--) begin
                if (tab_exp[i] < r.now) begin
                    tab_exp[i] = '0;
                    pick  = i;
                    found = 1'b1;
                end
            end
        end
        if (!found) begin
            rep.status = ST_FULL;
            return rep;
        end
        sum = {1'b0, r.now} + (TIME_W + 1)'(lock_dur);
        new_exp = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
        if (new_exp == 0)
            new_exp = 1;
        tab_dev[pick]  = r.dev;
        tab_path[pick] = r.path;
        tab_exp[pick]  = new_exp;
        rep.idx = OUT_IDX_W'(pick);
        return rep;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 4);
        else if (r < 98)
            return $urandom_range(5, 15);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic t_lock_req acquire_req(logic [DEV_W-1:0] d, logic [PATH_W-1:0] p,
                                              logic [TIME_W-1:0] t);
        t_lock_req r;
        r.cmd  = CMD_ACQUIRE;
        r.dev  = d;
        r.path = p;
        r.now  = t;
        r.rel  = REL_W'($urandom);
        return r;
    endfunction

    function automatic t_lock_req release_req(logic [REL_W-1:0] idx);
        t_lock_req r;
        r.cmd  = CMD_RELEASE;
        r.dev  = DEV_W'($urandom);
        r.path = {$urandom, $urandom};
        r.now  = $urandom;
        r.rel  = idx;
        return r;
    endfunction

    task automatic note_mismatch(string msg);
        errors++;
        if (errors <= 10)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    // Random traffic: mostly pooled keys on a slowly advancing clock
    task automatic gen_random(int n);
        int sel;
        int k;
        for (int j = 0; j < n; j++) begin
            sel = $urandom_range(0, 99);
            if (sel < 88)
                clock_s += $urandom_range(0, 3);
            else if (sel < 97)
                clock_s += $urandom_range(4, 400);
            sel = $urandom_range(0, 99);
            k   = $urandom_range(0, KEY_POOL - 1);
            if (sel < 70)
                pending_requests.push_back(acquire_req(key_dev[k], key_path[k], clock_s));
            else if (sel < 80)
                pending_requests.push_back(acquire_req(DEV_W'($urandom),
                                                       {$urandom, $urandom}, clock_s));
            else if (sel < 96)
                pending_requests.push_back(release_req(REL_W'($urandom_range(0, 63))));
            else
                pending_requests.push_back(acquire_req(key_dev[k], key_path[k], $urandom));
        end
    endtask

    task automatic wait_drained();
        while (pending_requests.size() != 0 || offering || awaited_replies.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_duration(logic [DUR_W-1:0] d);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        lock_dur = d;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Request driver
    always @(negedge i_clk) begin
        if (req_taken) begin
            req_taken = 1'b0;
            offering  = 1'b0;
            gap_left  = calm ? 0 : idle_len();
        end
        if (!offering) begin
            if (gap_left > 0)
                gap_left--;
            else if (pending_requests.size() > 0) begin
                cur_req  = pending_requests.pop_front();
                offering = 1'b1;
            end
        end
        i_s_tvalid <= offering;
        i_s_tdata  <= IN_DATA_W'({cur_req.rel, cur_req.now, cur_req.path, cur_req.dev});
        i_s_tuser  <= cur_req.cmd;
    end

    // Result receiver backpressure
    always @(negedge i_clk) begin
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left    = LONG_HOLD;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else begin
            stall_left = calm ? 0 : idle_len();
            i_m_tready <= (stall_left == 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    // Monitor: predict on request acceptance, check on result acceptance
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                awaited_replies.push_back(compute_lock_reply(cur_req));
                req_taken = 1'b1;
            end
            if (o_m_tvalid && i_m_tready) begin
                if (awaited_replies.size() == 0) begin
                    note_mismatch($sformatf("unexpected reply status=%0d idx=%0d",
                                            o_m_tuser, o_m_tdata[OUT_IDX_W-1:0]));
                end else begin
                    t_lock_reply want;
                    want = awaited_replies.pop_front();
                    if (o_m_tuser !== want.status || o_m_tdata[OUT_IDX_W-1:0] !== want.idx)
                        note_mismatch($sformatf("status exp=%0d got=%0d, idx exp=%0d got=%0d",
                                                want.status, o_m_tuser, want.idx,
                                                o_m_tdata[OUT_IDX_W-1:0]));
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Stimulus sequencing
    initial begin
        logic [DUR_W-1:0] phase_dur [PHASES];
        phase_dur = '{16'd300, 16'd0, 16'd1, 16'd65535, 16'd20,
                      16'd5, 16'd1000, 16'd3, 16'd65535, 16'd300};

        // pooled keys; odd keys share a path with a different device
        for (int k = 0; k < KEY_POOL; k++) begin
            key_dev[k]  = DEV_W'($urandom);
            key_path[k] = {$urandom, $urandom};
            if (k % 2 == 1) begin
                key_path[k] = key_path[k-1];
                key_dev[k]  = key_dev[k-1] ^ DEV_W'($urandom_range(1, 255));
            end
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                wait_drained();
                write_duration(phase_dur[ph]);
            end
            calm = (ph == 4 || ph == 7);
            if (ph == 1)
                clock_s = '0;
            if (ph == 8)
                clock_s = 32'hFFFF_FF00;

            if (ph == 0) begin
                // live match bounds, key parts, saturation, releases
                pending_requests.push_back(acquire_req(8'h00, 64'h0, 32'd0));
                pending_requests.push_back(acquire_req(8'h00, 64'h0, 32'd0));
                pending_requests.push_back(acquire_req(8'h00, 64'h0, 32'd300));
                pending_requests.push_back(acquire_req(8'h01, 64'h0, 32'd300));
                pending_requests.push_back(acquire_req(8'h00, 64'h1, 32'd300));
                pending_requests.push_back(acquire_req(8'h00, 64'h0, 32'd301));
                pending_requests.push_back(acquire_req(8'hFF, '1, 32'hFFFF_FFFF));
                pending_requests.push_back(acquire_req(8'hFF, '1, 32'd0));
                pending_requests.push_back(acquire_req(8'hFF, '1, 32'hFFFF_FFFF));
                pending_requests.push_back(release_req(6'd59));
                pending_requests.push_back(release_req(6'd59));
                pending_requests.push_back(release_req(6'd0));
                pending_requests.push_back(acquire_req(8'hFF, '1, 32'd5));
                pending_requests.push_back(release_req(6'd63));
                pending_requests.push_back(release_req(6'd62));
                clock_s = 32'd310;
            end
            if (ph == 1) begin
                // zero duration at time zero stores expiry one
                pending_requests.push_back(release_req(6'd60));
                pending_requests.push_back(release_req(6'd61));
                pending_requests.push_back(acquire_req(8'h02, 64'h2, 32'd0));
                pending_requests.push_back(acquire_req(8'h02, 64'h2, 32'd0));
                pending_requests.push_back(acquire_req(8'h02, 64'h2, 32'd1));
                pending_requests.push_back(acquire_req(8'h02, 64'h2, 32'd2));
                pending_requests.push_back(acquire_req(8'h03, 64'h3, 32'd0));
            end

            gen_random(RAND_ITEMS);
            if (ph == 2)
                long_hold_req = 1'b1;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: sim.f
src/tlt_pkg.sv
src/tlt_cell.sv
src/tlt_ctrl.sv
src/timed_lock_table.sv
src/tlt_checker.sv
bench/timed_lock_table_tb.sv
